FILE: src/mh2_pkg.sv
// Shared types and constants for the MurmurHash2 byte-stream hasher.
// Used by the controller, the datapath and the top level; depends on nothing.
package mh2_pkg;

  localparam logic [31:0] MIX_MUL   = 32'h5bd1e995;
  localparam int          SH_WORD   = 24;
  localparam int          SH_FIN_A  = 13;
  localparam int          SH_FIN_B  = 15;
  localparam int          DATA_W    = 8;
  localparam int          LEN_W     = 32;
  localparam int          HASH_W    = 32;
  localparam int          PEND_W    = 24;

  // One operation per cycle; each multiplying step uses the single shared multiplier.
  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_K1,
    DP_K2,
    DP_ACC,
    DP_TAIL,
    DP_FIN1,
    DP_FIN2
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   first;   // Seed the accumulator with the message length.
    logic   absorb;  // Fold the incoming byte into the pending word.
  } dp_cmd_t;

  typedef struct packed {
    logic word_full;  // Three bytes pending, so the next byte completes a word.
    logic len_zero;   // Length on the input bus is zero.
  } dp_sts_t;

endpackage

FILE: src/mh2_dp.sv
// Datapath of the MurmurHash2 hasher: accumulator, word packing and the shared multiplier.
// Depends on mh2_pkg; driven by mh2_ctrl through dp_cmd_t.
module mh2_dp
  import mh2_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  input  logic [DATA_W-1:0]   in_byte,
  input  logic [LEN_W-1:0]    in_len,
  output dp_sts_t             sts,
  output logic [HASH_W-1:0]   out_data
);

  logic [HASH_W-1:0] acc_r, acc_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [1:0]        pos_r, pos_nxt;
  logic [HASH_W-1:0] k_r, k_nxt;
  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [HASH_W-1:0] mul_a;
  logic [HASH_W-1:0] prod;

  assign prod = mul_a * MIX_MUL;

  always_comb begin
    acc_nxt  = acc_r;
    pend_nxt = pend_r;
    pos_nxt  = pos_r;
    k_nxt    = k_r;
    hash_nxt = hash_r;
    mul_a    = acc_r;
    case (cmd.op)
      DP_LOAD: begin
        if (cmd.first) begin
          acc_nxt = in_len;
        end
        if (cmd.absorb) begin
          case (pos_r)
            2'd0: begin
              pend_nxt[7:0] = in_byte;
              pos_nxt       = 2'd1;
            end
            2'd1: begin
              pend_nxt[15:8] = in_byte;
              pos_nxt        = 2'd2;
            end
            2'd2: begin
              pend_nxt[23:16] = in_byte;
              pos_nxt         = 2'd3;
            end
            default: begin
              k_nxt    = {in_byte, pend_r};
              pend_nxt = '0;
              pos_nxt  = 2'd0;
            end
          endcase
        end
      end
      DP_K1: begin
        mul_a = k_r;
        k_nxt = prod;
      end
      DP_K2: begin
        mul_a = k_r ^ (k_r >> SH_WORD);
        k_nxt = prod;
      end
      DP_ACC: begin
        mul_a   = acc_r;
        acc_nxt = prod ^ k_r;
      end
      DP_TAIL: begin
        mul_a = acc_r ^ {{(HASH_W-PEND_W){1'b0}}, pend_r};
        if (pos_r != 2'd0) begin
          acc_nxt = prod;
        end
      end
      DP_FIN1: begin
        mul_a   = acc_r ^ (acc_r >> SH_FIN_A);
        acc_nxt = prod;
      end
      DP_FIN2: begin
        hash_nxt = acc_r ^ (acc_r >> SH_FIN_B);
        acc_nxt  = '0;
        pend_nxt = '0;
        pos_nxt  = 2'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      pend_r <= '0;
      pos_r  <= 2'd0;
    end else begin
      acc_r  <= acc_nxt;
      pend_r <= pend_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    hash_r <= hash_nxt;
  end

  assign sts.word_full = (pos_r == 2'd3);
  assign sts.len_zero  = (in_len == '0);
  assign out_data      = hash_r;

endmodule

FILE: src/mh2_ctrl.sv
// Controller of the MurmurHash2 hasher: sequences the datapath and owns both handshakes.
// Depends on mh2_pkg; drives mh2_dp through dp_cmd_t and reads dp_sts_t.
module mh2_ctrl
  import mh2_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  logic    in_tlast,
  output logic    out_tvalid,
  input  logic    out_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_K1,
    S_K2,
    S_ACC,
    S_TAIL,
    S_FIN1,
    S_FIN2
  } state_t;

  state_t state_r, state_nxt;
  logic   in_msg_r, in_msg_nxt;
  logic   last_r, last_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   absorb;
  logic   word_done;
  logic   emit;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  // An empty message is one item that is both first and last with zero length.
  assign absorb     = !(!in_msg_r && in_tlast && sts.len_zero);
  assign word_done  = absorb && sts.word_full;
  assign emit       = (state_r == S_FIN2) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    in_msg_nxt    = in_msg_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    cmd.op        = DP_NOP;
    cmd.first     = 1'b0;
    cmd.absorb    = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.op     = DP_LOAD;
          cmd.first  = !in_msg_r;
          cmd.absorb = absorb;
          in_msg_nxt = 1'b1;
          last_nxt   = in_tlast;
          if (word_done) begin
            state_nxt = S_K1;
          end else if (in_tlast) begin
            state_nxt = S_TAIL;
          end
        end
      end
      S_K1: begin
        cmd.op    = DP_K1;
        state_nxt = S_K2;
      end
      S_K2: begin
        cmd.op    = DP_K2;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op    = DP_ACC;
        state_nxt = last_r ? S_TAIL : S_IDLE;
      end
      S_TAIL: begin
        cmd.op    = DP_TAIL;
        state_nxt = S_FIN1;
      end
      S_FIN1: begin
        cmd.op    = DP_FIN1;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        if (emit) begin
          cmd.op        = DP_FIN2;
          out_valid_nxt = 1'b1;
          in_msg_nxt    = 1'b0;
          last_nxt      = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_msg_r    <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_msg_r    <= in_msg_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A byte that completes a word must start the word mixing sequence.
  a_word_mix: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && word_done) |=> (state_r == S_K1))
    else $error("completed word did not start mixing");

  // The final step waits while the previous hash has not been taken.
  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN2 && out_valid_r && !out_tready) |=> (state_r == S_FIN2))
    else $error("final step overran an untaken hash");

  // A message ends only through the final step, which also raises the output valid.
  a_msg_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_msg_r) |-> ($past(state_r == S_FIN2) && out_valid_r))
    else $error("message ended without emitting a hash");

  // A last byte always leads to the tail step rather than back to idle.
  a_last_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tlast && !word_done) |=> (state_r == S_TAIL))
    else $error("last byte skipped the tail step");

endmodule

FILE: src/murmur2_hash_32_top.sv
// Top level of the MurmurHash2 (32-bit, seed zero) byte-stream hasher.
// Instantiates mh2_ctrl and mh2_dp; depends on mh2_pkg.
//
// This block computes the 32-bit MurmurHash2 of a byte message with a seed of
// zero. Each input beat carries one message byte and the total message length;
// the length is taken only on the first beat of a message and seeds the
// accumulator, and in_tlast marks the final byte. Bytes are unsigned and are
// packed little-endian into 32-bit words. An empty message is one beat with a
// length of zero and in_tlast set; its data byte is ignored. One hash beat is
// produced per message. A byte that does not complete a word is packed in the
// idle state. A byte that completes a word goes through three passes of the
// single shared 32 x 32 multiplier (two for the word, one for the accumulator)
// before the next byte is accepted. After the last byte come the tail fold, the
// first finalization multiply and the final xor-shift into the output
// register. The output register holds one finished hash, so the next message
// is accepted while that hash waits; the final step of a message waits only if
// the previous hash is still untaken. Reset is synchronous and active low.
module murmur2_hash_32_top
  import mh2_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [DATA_W+LEN_W-1:0] in_tdata,   // [7:0] data_byte, [39:8] message_length
  input  logic                    in_tlast,   // last_byte
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [HASH_W-1:0]       out_tdata   // [31:0] hash_value
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  mh2_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mh2_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_byte  (in_tdata[DATA_W-1:0]),
    .in_len   (in_tdata[DATA_W+LEN_W-1:DATA_W]),
    .sts      (sts),
    .out_data (out_tdata)
  );

endmodule
